// File: rtl/nvas_pkg.sv
// Shared types and constants of the virtual channel allocator and credit scheduler.
package nvas_pkg;

    localparam int NUM_VNETS_DEF    = 4;
    localparam int VCS_PER_VNET_DEF = 4;
    localparam int CMD_FIFO_DEPTH   = 2;

    localparam logic [4:0]  FLITS_MAX    = 5'd31;
    localparam logic [3:0]  CREDIT_MAX   = 4'd15;
    localparam logic [3:0]  CREDIT_RESET = 4'd4;
    localparam logic [31:0] STAMP_NONE   = 32'hFFFF_FFFF;

    // Configuration register indexes.
    localparam logic CFG_CREDITS_PER_VC = 1'b0;
    localparam logic CFG_ORDERED_MASK   = 1'b1;

    // Raw opcodes of an input transaction.
    typedef enum logic [1:0] {
        OP_INJECT = 2'd0,
        OP_TICK   = 2'd1,
        OP_CREDIT = 2'd2,
        OP_UNUSED = 2'd3
    } t_opcode;

    // Classified command kinds handed from the front end to the back end.
    typedef enum logic [2:0] {
        K_NULL,
        K_INJECT,
        K_TICK,
        K_CREDIT,
        K_ECHO
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [1:0] vnet;
        logic [4:0] flits;
        logic [3:0] ch;
        logic       free;
    } t_cmd;

    typedef struct packed {
        logic       done;
        logic [3:0] ch;
        logic       tail;
    } t_result;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_EXEC,
        BS_PICK
    } t_bstate;

endpackage

// File: rtl/nvas_front.sv
// Front end: accepts input transactions and classifies them into commands.
module nvas_front #(
    parameter int NUM_VNETS    = nvas_pkg::NUM_VNETS_DEF,
    parameter int VCS_PER_VNET = nvas_pkg::VCS_PER_VNET_DEF
) (
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic [1:0]     i_opcode,
    input  logic [1:0]     i_net_select,
    input  logic [4:0]     i_packet_flits,
    input  logic [3:0]     i_credit_channel,
    input  logic           i_channel_free,
    input  logic           i_q_full,
    output logic           o_q_push,
    output nvas_pkg::t_cmd o_q_cmd
);

    localparam int NUM_VCS = NUM_VNETS * VCS_PER_VNET;

    assign o_in_ready = !i_q_full;
    assign o_q_push   = i_in_valid && !i_q_full;

    always_comb begin
        o_q_cmd.vnet  = i_net_select;
        o_q_cmd.flits = i_packet_flits;
        o_q_cmd.ch    = i_credit_channel;
        o_q_cmd.free  = i_channel_free;
        case (nvas_pkg::t_opcode'(i_opcode))
            nvas_pkg::OP_INJECT: begin
                // An inject to a network that does not exist is refused outright.
                o_q_cmd.kind = (int'(i_net_select) < NUM_VNETS) ? nvas_pkg::K_INJECT
                                                                : nvas_pkg::K_NULL;
            end
            nvas_pkg::OP_TICK: begin
                o_q_cmd.kind = nvas_pkg::K_TICK;
            end
            nvas_pkg::OP_CREDIT: begin
                // A credit for a channel beyond the last one is only echoed.
                o_q_cmd.kind = (int'(i_credit_channel) < NUM_VCS) ? nvas_pkg::K_CREDIT
                                                                  : nvas_pkg::K_ECHO;
            end
            default: begin
                o_q_cmd.kind = nvas_pkg::K_NULL;
            end
        endcase
    end

endmodule

// File: rtl/nvas_fifo.sv
// Short command queue between the front end and the back end.
module nvas_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = nvas_pkg::CMD_FIFO_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             push_ok;
    logic             pop_ok;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push_ok) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop_ok) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push_ok && !pop_ok) begin
                r_count <= r_count + 1'b1;
            end else if (pop_ok && !push_ok) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// File: rtl/nvas_back.sv
// Back end: channel state, allocation, flit scheduling and the result register.
module nvas_back #(
    parameter int NUM_VNETS    = nvas_pkg::NUM_VNETS_DEF,
    parameter int VCS_PER_VNET = nvas_pkg::VCS_PER_VNET_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  nvas_pkg::t_cmd    i_q_cmd,
    output logic              o_q_pop,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [3:0]        i_cfg_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output nvas_pkg::t_result o_out
);

    localparam int NUM_VCS = NUM_VNETS * VCS_PER_VNET;
    localparam int CH_W    = (NUM_VCS > 1) ? $clog2(NUM_VCS) : 1;
    localparam int VN_W    = (NUM_VNETS > 1) ? $clog2(NUM_VNETS) : 1;
    localparam int VP_W    = (VCS_PER_VNET > 1) ? $clog2(VCS_PER_VNET) : 1;

    nvas_pkg::t_bstate r_state, n_state;
    nvas_pkg::t_cmd    r_cmd;
    nvas_pkg::t_result r_out;
    nvas_pkg::t_result out_value;
    logic              r_out_valid;

    logic [VP_W-1:0] r_alloc_ptr [NUM_VNETS];
    logic [VP_W-1:0] n_alloc_ptr [NUM_VNETS];
    logic            r_active    [NUM_VCS];
    logic            n_active    [NUM_VCS];
    logic [3:0]      r_credit    [NUM_VCS];
    logic [3:0]      n_credit    [NUM_VCS];
    logic [4:0]      r_flits     [NUM_VCS];
    logic [4:0]      n_flits     [NUM_VCS];
    logic [31:0]     r_stamp     [NUM_VCS];
    logic [31:0]     n_stamp     [NUM_VCS];
    logic [CH_W-1:0] r_out_ptr, n_out_ptr;
    logic [31:0]     r_time, n_time;
    logic [3:0]      r_mask;

    logic [NUM_VCS-1:0] elig;
    logic [NUM_VCS-1:0] r_elig_hi;
    logic [NUM_VCS-1:0] r_elig_lo;

    logic            out_free;
    logic            eval_en;
    logic            apply_inject;
    logic            apply_tick;
    logic            apply_credit;
    logic            load_out;

    logic [VN_W-1:0] vnet_idx;
    logic            inj_found;
    logic [VP_W-1:0] inj_idx;
    logic [CH_W-1:0] inj_vc;
    logic            pick_found;
    logic [CH_W-1:0] pick_vc;
    logic [CH_W-1:0] cred_vc;
    logic [5:0]      inj_sum;

    assign out_free = !r_out_valid || i_out_ready;
    assign vnet_idx = VN_W'(r_cmd.vnet);
    assign cred_vc  = CH_W'(r_cmd.ch);

    // Round-robin search for an idle channel of the requested network.
    always_comb begin : inj_search
        logic [VP_W:0] sum;
        logic [VP_W:0] wrapped;
        inj_found = 1'b0;
        inj_idx   = '0;
        for (int k = 0; k < VCS_PER_VNET; k++) begin
            sum     = {1'b0, r_alloc_ptr[vnet_idx]} + (VP_W + 1)'(k);
            wrapped = (sum >= (VP_W + 1)'(VCS_PER_VNET)) ? sum - (VP_W + 1)'(VCS_PER_VNET)
                                                         : sum;
            if (!inj_found
                && !r_active[CH_W'(int'(vnet_idx) * VCS_PER_VNET + int'(wrapped))]) begin
                inj_found = 1'b1;
                inj_idx   = VP_W'(wrapped);
            end
        end
        inj_vc = CH_W'(int'(vnet_idx) * VCS_PER_VNET + int'(inj_idx));
    end

    assign inj_sum = {1'b0, r_flits[inj_vc]} + {1'b0, r_cmd.flits};

    // A channel may send when it has flits and a credit, and on an ordered
    // network no pending channel of the same network arrived earlier.
    always_comb begin : elig_calc
        int  v;
        logic older;
        for (int c = 0; c < NUM_VCS; c++) begin
            v     = c / VCS_PER_VNET;
            older = 1'b0;
            for (int k = 0; k < VCS_PER_VNET; k++) begin
                if (r_flits[v * VCS_PER_VNET + k] != '0
                    && r_stamp[v * VCS_PER_VNET + k] < r_stamp[c]) begin
                    older = 1'b1;
                end
            end
            elig[c] = (r_flits[c] != '0) && (r_credit[c] != '0)
                      && !((v < 4) && r_mask[2'(v)] && older);
        end
    end

    // First eligible channel after the output pointer, wrapping round.
    always_comb begin : pick_search
        pick_found = |r_elig_lo;
        pick_vc    = '0;
        if (|r_elig_hi) begin
            for (int c = NUM_VCS - 1; c >= 0; c--) begin
                if (r_elig_hi[c]) begin
                    pick_vc = CH_W'(c);
                end
            end
        end else begin
            for (int c = NUM_VCS - 1; c >= 0; c--) begin
                if (r_elig_lo[c]) begin
                    pick_vc = CH_W'(c);
                end
            end
        end
    end

    // Sequencer: next state and control strobes.
    always_comb begin
        n_state      = r_state;
        o_q_pop      = 1'b0;
        eval_en      = 1'b0;
        apply_inject = 1'b0;
        apply_tick   = 1'b0;
        apply_credit = 1'b0;
        load_out     = 1'b0;
        out_value    = '0;
        case (r_state)
            nvas_pkg::BS_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_state = nvas_pkg::BS_EXEC;
                end
            end
            nvas_pkg::BS_EXEC: begin
                if (r_cmd.kind == nvas_pkg::K_TICK) begin
                    eval_en = 1'b1;
                    n_state = nvas_pkg::BS_PICK;
                end else if (out_free) begin
                    load_out = 1'b1;
                    n_state  = nvas_pkg::BS_IDLE;
                    case (r_cmd.kind)
                        nvas_pkg::K_INJECT: begin
                            apply_inject   = 1'b1;
                            out_value.done = inj_found;
                            out_value.ch   = inj_found ? 4'(inj_vc) : 4'd0;
                        end
                        nvas_pkg::K_CREDIT: begin
                            apply_credit   = 1'b1;
                            out_value.done = 1'b1;
                            out_value.ch   = r_cmd.ch;
                        end
                        nvas_pkg::K_ECHO: begin
                            out_value.done = 1'b1;
                            out_value.ch   = r_cmd.ch;
                        end
                        default: begin
                            out_value = '0;
                        end
                    endcase
                end
            end
            nvas_pkg::BS_PICK: begin
                if (out_free) begin
                    apply_tick     = 1'b1;
                    load_out       = 1'b1;
                    n_state        = nvas_pkg::BS_IDLE;
                    out_value.done = pick_found;
                    out_value.ch   = pick_found ? 4'(pick_vc) : 4'd0;
                    out_value.tail = pick_found && (r_flits[pick_vc] == 5'd1);
                end
            end
            default: begin
                n_state = nvas_pkg::BS_IDLE;
            end
        endcase
    end

    // Next values of the channel state.
    always_comb begin
        n_alloc_ptr = r_alloc_ptr;
        n_active    = r_active;
        n_credit    = r_credit;
        n_flits     = r_flits;
        n_stamp     = r_stamp;
        n_out_ptr   = r_out_ptr;
        n_time      = r_time;
        if (apply_inject && inj_found) begin
            n_active[inj_vc] = 1'b1;
            n_flits[inj_vc]  = (inj_sum > {1'b0, nvas_pkg::FLITS_MAX}) ? nvas_pkg::FLITS_MAX
                                                                       : inj_sum[4:0];
            n_stamp[inj_vc]  = r_time;
            n_alloc_ptr[vnet_idx] = (inj_idx == VP_W'(VCS_PER_VNET - 1)) ? '0
                                                                         : inj_idx + 1'b1;
        end
        if (apply_tick) begin
            n_time    = r_time + 32'd1;
            n_out_ptr = (r_out_ptr == CH_W'(NUM_VCS - 1)) ? '0 : r_out_ptr + 1'b1;
            if (pick_found) begin
                n_credit[pick_vc] = r_credit[pick_vc] - 4'd1;
                n_flits[pick_vc]  = r_flits[pick_vc] - 5'd1;
                if (r_flits[pick_vc] == 5'd1) begin
                    n_stamp[pick_vc] = nvas_pkg::STAMP_NONE;
                end
            end
        end
        if (apply_credit) begin
            if (r_credit[cred_vc] != nvas_pkg::CREDIT_MAX) begin
                n_credit[cred_vc] = r_credit[cred_vc] + 4'd1;
            end
            if (r_cmd.free) begin
                n_active[cred_vc] = 1'b0;
            end
        end
        if (i_cfg_we && (i_cfg_index == nvas_pkg::CFG_CREDITS_PER_VC)) begin
            for (int c = 0; c < NUM_VCS; c++) begin
                n_credit[c] = i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= nvas_pkg::BS_IDLE;
            r_out_valid <= 1'b0;
            r_out_ptr   <= '0;
            r_time      <= '0;
            r_mask      <= '0;
            for (int n = 0; n < NUM_VNETS; n++) begin
                r_alloc_ptr[n] <= '0;
            end
            for (int c = 0; c < NUM_VCS; c++) begin
                r_active[c] <= 1'b0;
                r_credit[c] <= nvas_pkg::CREDIT_RESET;
                r_flits[c]  <= '0;
                r_stamp[c]  <= nvas_pkg::STAMP_NONE;
            end
        end else begin
            r_state     <= n_state;
            r_alloc_ptr <= n_alloc_ptr;
            r_active    <= n_active;
            r_credit    <= n_credit;
            r_flits     <= n_flits;
            r_stamp     <= n_stamp;
            r_out_ptr   <= n_out_ptr;
            r_time      <= n_time;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we && (i_cfg_index == nvas_pkg::CFG_ORDERED_MASK)) begin
                r_mask <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cmd <= i_q_cmd;
        end
        if (eval_en) begin
            for (int c = 0; c < NUM_VCS; c++) begin
                r_elig_hi[c] <= elig[c] && (CH_W'(c) > r_out_ptr);
            end
            r_elig_lo <= elig;
        end
        if (load_out) begin
            r_out <= out_value;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// File: rtl/noc_ni_vc_alloc_and_credit_scheduler.sv
// Top level of the network interface virtual channel allocator and credit scheduler.
// The result is registered; the back-end sequencer takes one command at a time through
// pop and execute, and for ticks an extra eligibility stage before the pick, and it holds
// before loading a result while the earlier result has not been taken.
// A two-entry command queue lets the input keep accepting while a result waits.
// Reset (synchronous, active low) idles all channels, loads 4 credits per channel,
// clears pointers, flit counts and time, and marks every arrival stamp as none.
module noc_ni_vc_alloc_and_credit_scheduler #(
    parameter int NUM_VNETS    = nvas_pkg::NUM_VNETS_DEF,
    parameter int VCS_PER_VNET = nvas_pkg::VCS_PER_VNET_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_opcode,
    input  logic [1:0] i_net_select,
    input  logic [4:0] i_packet_flits,
    input  logic [3:0] i_credit_channel,
    input  logic       i_channel_free,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_done_flag,
    output logic [3:0] o_channel,
    output logic       o_tail_flag,
    input  logic       i_cfg_we,
    input  logic       i_cfg_index,
    input  logic [3:0] i_cfg_data
);

    localparam int CMD_W = $bits(nvas_pkg::t_cmd);

    logic              q_full;
    logic              q_push;
    logic              q_pop;
    logic              q_valid;
    nvas_pkg::t_cmd    front_cmd;
    logic [CMD_W-1:0]  q_data;
    nvas_pkg::t_result result;

    // The front end classifies each transaction as it is accepted, so the
    // back end only sees commands it can carry out directly.
    nvas_front #(
        .NUM_VNETS    (NUM_VNETS),
        .VCS_PER_VNET (VCS_PER_VNET)
    ) u_front (
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_opcode         (i_opcode),
        .i_net_select     (i_net_select),
        .i_packet_flits   (i_packet_flits),
        .i_credit_channel (i_credit_channel),
        .i_channel_free   (i_channel_free),
        .i_q_full         (q_full),
        .o_q_push         (q_push),
        .o_q_cmd          (front_cmd)
    );

    // The queue decouples acceptance from execution.
    nvas_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (nvas_pkg::CMD_FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    // The back end holds all channel state and the registered result.
    nvas_back #(
        .NUM_VNETS    (NUM_VNETS),
        .VCS_PER_VNET (VCS_PER_VNET)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_cmd     (nvas_pkg::t_cmd'(q_data)),
        .o_q_pop     (q_pop),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (result)
    );

    assign o_done_flag = result.done;
    assign o_channel   = result.ch;
    assign o_tail_flag = result.tail;

endmodule
